>>> rtl/crsi_pkg.sv
package crsi_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = 9;
	localparam int XW          = 36;
	localparam int WW          = 33;

	localparam logic [0:0] KIND_LOAD  = 1'b0;
	localparam logic [0:0] KIND_QUERY = 1'b1;

	localparam logic [1:0] POS_INSIDE = 2'd0;
	localparam logic [1:0] POS_BELOW  = 2'd1;
	localparam logic [1:0] POS_ABOVE  = 2'd2;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [WW-1:0] ONE_Q32 = 33'h1_0000_0000;

	typedef struct packed {
		logic [XW-1:0] red;
		logic [XW-1:0] green;
		logic [XW-1:0] blue;
	} ytriple_t;

endpackage

>>> rtl/curve_resample_interpolator.sv
// Piecewise-linear curve resampler. A load item (kind 0) writes one table
// entry and leaves the input free for the next item. A query item (kind 1)
// scans the x memory one entry a cycle for the first bracket around its x,
// reads the two y values, divides one quotient bit a cycle and scales in two
// multiply steps. A query keeps the input stalled from its transfer until its
// result moves to the output register, through the scan of the x memory and,
// inside a bracket, the 32-step divider. A zero span skips the divider, and a
// query that lands below or above the table or finds no bracket goes straight
// to the result. A finished result waits in an output register while the
// next item is taken.
module curve_resample_interpolator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [crsi_pkg::CW-1:0]  cfg_write_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [0:0]               kind,
	input  logic [7:0]               entry_index,
	input  logic signed [35:0]       point_x,
	input  logic signed [35:0]       point_y_red,
	input  logic signed [35:0]       point_y_green,
	input  logic signed [35:0]       point_y_blue,
	input  logic [1:0]               channel,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [35:0]       mapped_value,
	output logic [32:0]              weight,
	output logic [7:0]               lower_entry,
	output logic [7:0]               upper_entry,
	output logic [1:0]               position,
	output logic                     search_failed
);
	import crsi_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FIRST = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_YA    = 4'd3;
	localparam logic [3:0] S_YB    = 4'd4;
	localparam logic [3:0] S_YC    = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_RND   = 4'd7;
	localparam logic [3:0] S_MUL1  = 4'd8;
	localparam logic [3:0] S_MUL2  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]           state_q;
	logic [CW-1:0]        count_q, n_q, idx_q;
	logic signed [XW-1:0] q_q, xl_q, xr_q, yl_q, yr_q;
	logic [1:0]           ch_q;
	logic [7:0]           li_q, ri_q;
	logic [1:0]           pos_q;
	logic                 fail_q;
	logic [XW-1:0]        val_q;
	logic [37:0]          rem_q, span_q;
	logic [WW-1:0]        quot_q;
	logic [5:0]           dcnt_q;
	logic [64:0]          plo_q;
	logic [4:0]           hi_q;
	logic                 neg_q;

	logic                 in_xfer, load_we;
	logic [AW-1:0]        x_raddr, y_raddr;
	logic [XW-1:0]        x_rdata;
	ytriple_t             y_wdata, y_rdata;
	logic [XW-1:0]        y_sel;
	logic [CW-1:0]        n_eff;
	logic                 last;
	logic signed [XW-1:0] xr_c;
	logic [37:0]          span_c, d_c, rem2_c, diff_c, mag_c;
	logic [37:0]          p_c;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign load_we  = in_xfer && (kind == KIND_LOAD) && (32'(entry_index) < TABLE_DEPTH);

	assign y_wdata = '{red: point_y_red, green: point_y_green, blue: point_y_blue};

	crsi_ram #(.WIDTH(XW), .DEPTH(TABLE_DEPTH)) u_x_ram (
		.clk(clk), .we(load_we), .waddr(AW'(entry_index)), .wdata(point_x),
		.raddr(x_raddr), .rdata(x_rdata)
	);

	crsi_ram #(.WIDTH($bits(ytriple_t)), .DEPTH(TABLE_DEPTH)) u_y_ram (
		.clk(clk), .we(load_we), .waddr(AW'(entry_index)), .wdata(y_wdata),
		.raddr(y_raddr), .rdata(y_rdata)
	);

	always_comb begin
		unique case (state_q)
			S_FIRST: x_raddr = AW'(1);
			S_SCAN:  x_raddr = AW'(idx_q + CW'(2));
			default: x_raddr = '0;
		endcase
		y_raddr = (state_q == S_YA) ? AW'(li_q) : AW'(ri_q);
		unique case (ch_q)
			CH_RED:   y_sel = y_rdata.red;
			CH_GREEN: y_sel = y_rdata.green;
			default:  y_sel = y_rdata.blue;
		endcase
	end

	assign n_eff  = (32'(cfg_write_data) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : cfg_write_data;
	assign last   = ((idx_q + CW'(1)) >= n_q);
	assign xr_c   = last ? xl_q : x_rdata;
	assign span_c = 38'($signed(xr_q)) - 38'($signed(xl_q));
	assign d_c    = 38'($signed(q_q)) - 38'($signed(xl_q));
	assign rem2_c = {rem_q[36:0], 1'b0};
	assign diff_c = 38'($signed(yr_q)) - 38'($signed(yl_q));
	assign mag_c  = diff_c[37] ? (38'd0 - diff_c) : diff_c;
	assign p_c    = 38'(quot_q * hi_q) + 38'(plo_q[64:32]) + 38'(plo_q[31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(TABLE_DEPTH);
		end else if (cfg_write_en) begin
			count_q <= n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && kind == KIND_QUERY) begin
						state_q <= (count_q == '0) ? S_DONE : S_FIRST;
					end
				end
				S_FIRST: state_q <= S_SCAN;
				S_SCAN: begin
					if ((xl_q <= q_q && q_q <= xr_c) || last || (idx_q == '0 && q_q <= xl_q)) begin
						state_q <= (xl_q <= q_q && q_q <= xr_c) ? S_YA : S_DONE;
					end
				end
				S_YA: state_q <= S_YB;
				S_YB: state_q <= S_YC;
				S_YC: state_q <= ($signed(span_c) > 38'sd0) ? S_DIV : S_MUL1;
				S_DIV: begin
					if (dcnt_q == 6'd1) begin
						state_q <= S_RND;
					end
				end
				S_RND:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				q_q    <= point_x;
				ch_q   <= channel;
				n_q    <= count_q;
				idx_q  <= '0;
				li_q   <= '0;
				ri_q   <= '0;
				pos_q  <= POS_INSIDE;
				val_q  <= '0;
				quot_q <= '0;
				fail_q <= 1'b1;
			end
			S_FIRST: xl_q <= x_rdata;
			S_SCAN: begin
				if (xl_q <= q_q && q_q <= xr_c) begin
					li_q   <= 8'(idx_q);
					ri_q   <= last ? 8'(idx_q) : 8'(idx_q + CW'(1));
					xr_q   <= xr_c;
					fail_q <= 1'b0;
				end else if (idx_q == '0 && q_q <= xl_q) begin
					pos_q  <= POS_BELOW;
					fail_q <= 1'b0;
				end else if (last && xr_c <= q_q) begin
					li_q   <= 8'(idx_q);
					ri_q   <= 8'(idx_q);
					pos_q  <= POS_ABOVE;
					val_q  <= XW'(ONE_Q32);
					quot_q <= ONE_Q32;
					fail_q <= 1'b0;
				end else begin
					xl_q  <= x_rdata;
					idx_q <= idx_q + CW'(1);
				end
			end
			S_YB: yl_q <= y_sel;
			S_YC: begin
				yr_q   <= y_sel;
				span_q <= span_c;
				dcnt_q <= 6'd32;
				// a zero span keeps the weight at zero
				if (($signed(span_c) > 38'sd0) && (d_c >= span_c)) begin
					quot_q <= WW'(1);
					rem_q  <= d_c - span_c;
				end else begin
					quot_q <= '0;
					rem_q  <= d_c;
				end
			end
			S_DIV: begin
				dcnt_q <= dcnt_q - 6'd1;
				if (rem2_c >= span_q) begin
					rem_q  <= rem2_c - span_q;
					quot_q <= {quot_q[WW-2:0], 1'b1};
				end else begin
					rem_q  <= rem2_c;
					quot_q <= {quot_q[WW-2:0], 1'b0};
				end
			end
			S_RND: begin
				if (rem_q >= span_q - rem_q) begin
					quot_q <= quot_q + WW'(1);
				end
			end
			S_MUL1: begin
				plo_q <= quot_q * mag_c[31:0];
				hi_q  <= mag_c[36:32];
				neg_q <= diff_c[37];
			end
			S_MUL2: val_q <= XW'(yl_q) + (neg_q ? XW'(38'd0 - p_c) : XW'(p_c));
			S_DONE: begin
				if (!out_valid || !out_stall) begin
					mapped_value  <= val_q;
					weight        <= quot_q;
					lower_entry   <= li_q;
					upper_entry   <= ri_q;
					position      <= pos_q;
					search_failed <= fail_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/crsi_ram.sv
module crsi_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/crsi_checker.sv
module crsi_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [0:0]  kind,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [35:0] mapped_value,
	input  logic [32:0] weight,
	input  logic [1:0]  position,
	input  logic        search_failed
);
	import crsi_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mapped_value))
		else $error("stalled result dropped or changed");

	// a query transfer keeps the input side busy while it works
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_QUERY |=> in_stall)
		else $error("input taken during a query");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && search_failed |-> mapped_value == '0 && weight == '0
			&& position == POS_INSIDE)
		else $error("failed search with nonzero result");

	a_above_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position == POS_ABOVE |-> weight == ONE_Q32 && !search_failed)
		else $error("above result without unit weight");

endmodule

bind curve_resample_interpolator crsi_checker u_crsi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
	.out_valid(out_valid), .out_stall(out_stall), .mapped_value(mapped_value),
	.weight(weight), .position(position), .search_failed(search_failed)
);
